>>> rtl/core/svwr_pkg.sv
`default_nettype none

package svwr_pkg;

    // 2*pi * 1e9 * 2^16, floored; the Q16.16 scale of the velocity is folded in
    localparam int unsigned K_W = 49;
    localparam logic [K_W-1:0] TWO_PI_NS_Q16 = 49'd411774832291321;

    // |velocity| <= 2^31 times microsteps < 2^21 stays below 2^52
    localparam int unsigned DEN_W = 52;
    localparam int unsigned MAG_W = 32;
    localparam int unsigned MSTEP_W = 21;

    // One quotient bit per divider step
    localparam int unsigned DIV_STEPS = K_W;
    localparam int unsigned STEP_W = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd0;
    localparam logic [1:0] REG_MIN_INTERVAL = 2'd1;
    localparam logic [1:0] REG_MAX_INTERVAL = 2'd2;
    localparam logic [1:0] REG_MICROSTEPS = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_RUNNING = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // take the input word, update the watchdog
        logic prep;      // form the divisor and load the divider
        logic div_step;  // one restoring division step
        logic load;      // move the result into the output register
    } svwr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic early;     // timed out or zero velocity: no division needed
        logic out_free;  // output register can take a word this cycle
    } svwr_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/stepper_velocity_watchdog_rate.sv
`default_nettype none

// Stepper step-rate generator with command watchdog. Each input word is one
// control tick: a fresh command latches its velocity (signed Q16.16 rad/s)
// and clears the tick count; otherwise the count rises to timeout_ticks and
// the tick after that forces the held velocity to zero with status "timed
// out". Each tick yields one output word holding the microstep interval
// floor(2*pi*1e9 / (|velocity| * microsteps_per_rev)) in ns on step_period_ns,
// the direction and a status; stopped words carry direction 0 and interval 0.
// A tick that runs the divider occupies the block through the accepting
// cycle (watchdog update), the divisor multiply, 49 restoring division
// steps of one quotient bit each and the output load, after which its
// result word is valid; a tick that times out or holds zero velocity
// skips the division steps and passes straight from the divisor multiply to
// the output load. A full output register that is not being taken stretches
// the load cycle until it frees. The next word is accepted as soon as the
// result is in the output register, even while it waits to be taken. Write
// configuration only while the block is idle.
module stepper_velocity_watchdog_rate
    import svwr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        new_command,
    input  wire logic [31:0] velocity,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             running,
    output logic             direction,
    output logic [31:0]      step_period_ns,
    output logic [1:0]       status
);

    svwr_cmd_t  cmd;
    svwr_stat_t stat;

    svwr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    svwr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .new_command    (new_command),
        .velocity       (velocity),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .running        (running),
        .direction      (direction),
        .step_period_ns (step_period_ns),
        .status         (status)
    );

endmodule

`default_nettype wire

>>> rtl/core/svwr_ctrl.sv
`default_nettype none

module svwr_ctrl
    import svwr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire svwr_stat_t stat,
    output svwr_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.accept   = 1'b0;
        cmd.prep     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep  = 1'b1;
                step_next = '0;
                if (stat.early)
                    state_next = ST_FIN;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/svwr_datapath.sv
`default_nettype none

module svwr_datapath
    import svwr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire svwr_cmd_t   cmd,
    output svwr_stat_t       stat,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        new_command,
    input  wire logic [31:0] velocity,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             running,
    output logic             direction,
    output logic [31:0]      step_period_ns,
    output logic [1:0]       status
);

    logic [15:0]         timeout_ticks_reg;
    logic [29:0]         min_interval_reg;
    logic [31:0]         max_interval_reg;
    logic [MSTEP_W-1:0]  microsteps_reg;

    logic [31:0]         held_velocity_reg;
    logic [15:0]         ticks_reg;
    logic                timed_out_reg;

    logic                negative_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [K_W-1:0]      quo_reg;

    logic                out_valid_reg;
    logic                running_reg;
    logic                direction_reg;
    logic [31:0]         interval_reg;
    logic [1:0]          status_reg;

    logic [MAG_W-1:0]    mag;
    logic [MAG_W+MSTEP_W-1:0] prod;
    logic [DEN_W:0]      trial;
    logic [DEN_W:0]      diff;
    logic                fits;
    logic                zero_vel;
    logic                in_range;
    logic                res_running;
    logic [1:0]          res_status;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= 16'd20;
            min_interval_reg  <= 30'd20000;
            max_interval_reg  <= 32'd1000000000;
            microsteps_reg    <= MSTEP_W'(200);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                REG_MIN_INTERVAL:  min_interval_reg  <= cfg_data[29:0];
                REG_MAX_INTERVAL:  max_interval_reg  <= cfg_data;
                REG_MICROSTEPS:    microsteps_reg    <= cfg_data[MSTEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // Watchdog: latch a fresh command, else count up, else force zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_velocity_reg <= '0;
            ticks_reg         <= '0;
            timed_out_reg     <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (new_command)
            begin
                held_velocity_reg <= velocity;
                ticks_reg         <= '0;
                timed_out_reg     <= 1'b0;
            end
            else if (ticks_reg < timeout_ticks_reg)
            begin
                ticks_reg     <= ticks_reg + 16'd1;
                timed_out_reg <= 1'b0;
            end
            else
            begin
                held_velocity_reg <= '0;
                timed_out_reg     <= 1'b1;
            end
        end
    end

    // Magnitude; the most negative value maps onto 2^31 by itself
    assign mag  = held_velocity_reg[31] ? (~held_velocity_reg + 32'd1) : held_velocity_reg;
    assign prod = mag * microsteps_reg;

    assign zero_vel   = (held_velocity_reg == '0);
    assign stat.early = timed_out_reg || zero_vel;

    // Restoring division step
    assign trial = {rem_reg, quo_reg[K_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // Load the divider, then shift in one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            negative_reg <= held_velocity_reg[31];
            den_reg      <= prod[DEN_W-1:0];
            rem_reg      <= '0;
            quo_reg      <= TWO_PI_NS_Q16;
        end
        else if (cmd.div_step)
        begin
            if (fits)
            begin
                rem_reg <= diff[DEN_W-1:0];
                quo_reg <= {quo_reg[K_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[K_W-2:0], 1'b0};
            end
        end
    end

    // Check the exact quotient against the configured window
    assign in_range = (quo_reg[K_W-1:32] == '0)
                   && (quo_reg[31:0] >= {2'b00, min_interval_reg})
                   && ((quo_reg[31:0] < max_interval_reg)
                       || ((quo_reg[31:0] == max_interval_reg) && (rem_reg == '0)));

    always_comb
    begin
        res_running = 1'b0;
        priority if (timed_out_reg)
            res_status = STATUS_TIMEOUT;
        else if (zero_vel)
            res_status = STATUS_ZERO;
        else if (!in_range)
            res_status = STATUS_RANGE;
        else
        begin
            res_status  = STATUS_RUNNING;
            res_running = 1'b1;
        end
    end

    // Output word register
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            running_reg   <= res_running;
            direction_reg <= res_running && negative_reg;
            interval_reg  <= res_running ? quo_reg[31:0] : 32'd0;
            status_reg    <= res_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign running        = running_reg;
    assign direction      = direction_reg;
    assign step_period_ns = interval_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire
